### hw/rtl/peer_tunnel_id_allocator_macros.svh
// ----------------------------------------------------------------------------
// Peer tunnel id allocator: assertion macros
// Checks are compiled in simulation and drop out under synthesis.
// ----------------------------------------------------------------------------
`ifndef PEER_TUNNEL_ID_ALLOCATOR_MACROS_SVH
`define PEER_TUNNEL_ID_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define PTID_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptid check failed: same cycle");
// consequent must hold in the cycle after the antecedent
`define PTID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptid check failed: next cycle");
`else
`define PTID_ASSERT_SAME(label, clk, rst, ante, cons)
`define PTID_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/ptid_pkg.sv
// ----------------------------------------------------------------------------
// Peer tunnel id allocator: shared package
// Types, codes and sizes used by the front end, command queue and back end.
// ----------------------------------------------------------------------------
package ptid_pkg;

   // peer table size
   localparam int PEER_ENTRIES = 16;
   localparam int IDX_W        = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;

   // tunnel id layout
   localparam int          ID_SHIFT    = 24;
   localparam int          PREFIX_BITS = 8;
   localparam logic [31:0] FULL_MASK   = 32'hFFFF_FFFF;
   localparam logic [31:0] FIRST_ID    = 32'h0000_0001;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // configuration port
   localparam int         CSR_IDX_W      = 2;
   localparam int         CSR_DATA_W     = 4;
   localparam logic [1:0] CSR_RANGE_BITS = 2'd0;
   localparam logic [1:0] CSR_NODE_ROLE  = 2'd1;

   // actions
   localparam logic [1:0] ACT_SETUP  = 2'd0;
   localparam logic [1:0] ACT_ALLOC  = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // interfaces
   localparam logic [1:0] IF_S1U_SGW  = 2'd0;
   localparam logic [1:0] IF_S5S8_SGW = 2'd1;
   localparam logic [1:0] IF_S5S8_PGW = 2'd2;

   // node roles
   localparam logic [1:0] ROLE_SGW      = 2'd0;
   localparam logic [1:0] ROLE_COMBINED = 2'd1;
   localparam logic [1:0] ROLE_PGW      = 2'd2;

   // result status
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] peer_address;
      logic [7:0]  range_value;
      logic [1:0]  interface_select;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] teid;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] peer_address;
      logic [7:0]  prefix;
      logic        prefix_en;
      logic [31:0] mask;
      logic        advance;
   } cmd_type;

endpackage

### hw/rtl/peer_tunnel_id_allocator.sv
// ----------------------------------------------------------------------------
// Peer tunnel id allocator: top level
//
//   channel   ports                                 beat taken when
//   request   start, busy, req_item                 start && !busy
//   result    rsp_valid, rsp_item                   rsp_valid (one cycle)
//   config    csr_valid, csr_ready, csr_index,      csr_valid && csr_ready
//             csr_wdata
//
// From acceptance to its result a request leaves the queue, is scanned against
// the table entry by entry (the scan stops at the matching peer) and is then
// executed. The table scan sets the rate.
// Two requests can wait in the command queue; busy is high while it is full.
// Reset is synchronous and clears the queue, sequencer, valid bits and
// configuration. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`include "peer_tunnel_id_allocator_macros.svh"

module peer_tunnel_id_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ptid_pkg::req_type               req_item,
   output logic                            rsp_valid,
   output ptid_pkg::rsp_type               rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ptid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptid_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ptid_pkg::*;

   logic    q_push, q_full, q_pop, q_not_empty;
   cmd_type push_cmd, head_cmd;

   assign busy = q_full;

   ptid_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ptid_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   ptid_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (head_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

   // checks
   `PTID_ASSERT_SAME(a_no_overflow, clock, reset, q_push, !q_full)
   `PTID_ASSERT_SAME(a_teid_ok, clock, reset, rsp_valid && |rsp_item.teid, rsp_item.status == ST_OK)
   `PTID_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `PTID_ASSERT_NEXT(a_pop_scans, clock, reset, q_pop, !rsp_valid && !q_pop)

endmodule

### hw/rtl/ptid_front.sv
// ----------------------------------------------------------------------------
// Peer tunnel id allocator: front end
// Holds the configuration registers and classifies each request beat
// (prefix, id mask, role match) before it enters the command queue.
// ----------------------------------------------------------------------------
module ptid_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  ptid_pkg::req_type              req_item,
   input  logic                           q_full,
   output logic                           q_push,
   output ptid_pkg::cmd_type              q_cmd,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ptid_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptid_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ptid_pkg::*;

   logic [3:0]  range_bits_ff, range_bits_in;
   logic [1:0]  node_role_ff, node_role_in;
   logic [3:0]  rb_eff;
   logic [15:0] prefix_wide;
   logic        advance;

   // configuration writes, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      range_bits_in = range_bits_ff;
      node_role_in  = node_role_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_BITS: range_bits_in = csr_wdata[3:0];
            CSR_NODE_ROLE:  node_role_in  = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_bits_ff <= 4'd0;
         node_role_ff  <= 2'd0;
      end else begin
         range_bits_ff <= range_bits_in;
         node_role_ff  <= node_role_in;
      end
   end

   // range bits saturate at one byte
   always_comb begin
      rb_eff = (range_bits_ff > 4'(PREFIX_BITS)) ? 4'(PREFIX_BITS) : range_bits_ff;
      prefix_wide = {8'h00, req_item.range_value} << (4'(PREFIX_BITS) - rb_eff);
   end

   // role against interface
   always_comb begin
      case (req_item.interface_select)
         IF_S1U_SGW, IF_S5S8_SGW: advance = node_role_ff inside {ROLE_SGW, ROLE_COMBINED};
         IF_S5S8_PGW:             advance = (node_role_ff == ROLE_PGW);
         default:                 advance = 1'b0;
      endcase
   end

   // classified beat into the queue
   assign q_push = start && !q_full;

   always_comb begin
      q_cmd.action       = req_item.action;
      q_cmd.peer_address = req_item.peer_address;
      q_cmd.prefix       = prefix_wide[7:0];
      q_cmd.prefix_en    = (rb_eff != 4'd0);
      q_cmd.mask         = FULL_MASK >> rb_eff;
      q_cmd.advance      = advance;
   end

endmodule

### hw/rtl/ptid_cmd_queue.sv
// ----------------------------------------------------------------------------
// Peer tunnel id allocator: command queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ptid_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptid_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ptid_pkg::cmd_type head_cmd
);
   import ptid_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/ptid_back.sv
// ----------------------------------------------------------------------------
// Peer tunnel id allocator: back end
// Owns the peer table. Scans it one entry a cycle for the peer and the
// lowest free slot, then carries out the command and strobes the result.
// ----------------------------------------------------------------------------
module ptid_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  ptid_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   output ptid_pkg::rsp_type rsp_item
);
   import ptid_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   // peer table
   logic [PEER_ENTRIES-1:0] valid_ff;
   logic [31:0]             peer_ff   [PEER_ENTRIES];
   logic [7:0]              prefix_ff [PEER_ENTRIES];
   logic [31:0]             base_ff   [PEER_ENTRIES];
   logic [31:0]             offset_ff [PEER_ENTRIES];
   logic [31:0]             last_ff   [PEER_ENTRIES];

   // sequencer and captured hit
   logic [1:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             found_ff, found_in;
   logic             free_ok_ff, free_ok_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [7:0]       hit_prefix_ff, hit_prefix_in;
   logic [31:0]      hit_base_ff, hit_base_in;
   logic [31:0]      hit_offset_ff, hit_offset_in;
   logic [31:0]      hit_last_ff, hit_last_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   // table write controls
   logic             wr_set, wr_clr, wr_peer, wr_pb, wr_off, wr_last;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       wr_prefix;
   logic [31:0]      wr_base, wr_offset, wr_last_id;

   // execute-stage helpers
   logic [31:0] sum_id, id_sel, new_base;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign q_pop     = (state_ff == S_IDLE) && q_not_empty;

   always_comb begin
      sum_id   = hit_base_ff + hit_offset_ff;
      new_base = {cmd_ff.prefix, 24'h00_0000} | 32'(cmd_ff.prefix == 8'h00);
      id_sel   = cmd_ff.advance ? sum_id : hit_last_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      free_ok_in    = free_ok_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      hit_prefix_in = hit_prefix_ff;
      hit_base_in   = hit_base_ff;
      hit_offset_in = hit_offset_ff;
      hit_last_in   = hit_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr_set        = 1'b0;
      wr_clr        = 1'b0;
      wr_peer       = 1'b0;
      wr_pb         = 1'b0;
      wr_off        = 1'b0;
      wr_last       = 1'b0;
      wr_idx        = hit_idx_ff;
      wr_prefix     = cmd_ff.prefix;
      wr_base       = new_base;
      wr_offset     = '0;
      wr_last_id    = FIRST_ID;
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               cmd_in     = q_cmd;
               cnt_in     = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         // one entry per cycle; first match wins, lowest free slot noted
         S_SCAN: begin
            if (valid_ff[cnt_ff] && peer_ff[cnt_ff] == cmd_ff.peer_address) begin
               found_in      = 1'b1;
               hit_idx_in    = cnt_ff;
               hit_prefix_in = prefix_ff[cnt_ff];
               hit_base_in   = base_ff[cnt_ff];
               hit_offset_in = offset_ff[cnt_ff];
               hit_last_in   = last_ff[cnt_ff];
               state_in      = S_EXEC;
            end else begin
               if (!valid_ff[cnt_ff] && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = cnt_ff;
               end
               if (cnt_ff == IDX_W'(PEER_ENTRIES - 1)) begin
                  state_in = S_EXEC;
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EXEC: begin
            rsp_valid_in       = 1'b1;
            rsp_item_in.status = ST_OK;
            rsp_item_in.teid   = '0;
            state_in           = S_IDLE;
            case (cmd_ff.action)
               ACT_SETUP: begin
                  if (found_ff) begin
                     wr_pb = cmd_ff.prefix_en;
                  end else if (free_ok_ff) begin
                     wr_idx    = free_idx_ff;
                     wr_set    = 1'b1;
                     wr_peer   = 1'b1;
                     wr_pb     = 1'b1;
                     wr_off    = 1'b1;
                     wr_last   = 1'b1;
                     wr_prefix = cmd_ff.prefix_en ? cmd_ff.prefix : 8'h00;
                     wr_base   = cmd_ff.prefix_en ? new_base : FIRST_ID;
                  end else begin
                     rsp_item_in.status = ST_TABLE_FULL;
                  end
               end
               ACT_ALLOC: begin
                  if (!found_ff) begin
                     rsp_item_in.status = ST_NOT_FOUND;
                  end else begin
                     wr_off     = cmd_ff.advance;
                     wr_last    = cmd_ff.advance;
                     wr_last_id = sum_id;
                     wr_offset  = (hit_offset_ff >= cmd_ff.mask) ? 32'd0
                                                                : hit_offset_ff + 32'd1;
                     rsp_item_in.teid = (id_sel & cmd_ff.mask)
                                        | {hit_prefix_ff, 24'h00_0000};
                  end
               end
               ACT_REMOVE: begin
                  if (!found_ff) begin
                     rsp_item_in.status = ST_NOT_FOUND;
                  end else begin
                     wr_clr = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_set) begin
            valid_ff[wr_idx] <= 1'b1;
         end else if (wr_clr) begin
            valid_ff[wr_idx] <= 1'b0;
         end
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      free_ok_ff    <= free_ok_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      hit_prefix_ff <= hit_prefix_in;
      hit_base_ff   <= hit_base_in;
      hit_offset_ff <= hit_offset_in;
      hit_last_ff   <= hit_last_in;
      rsp_item_ff   <= rsp_item_in;
   end

   // table writes
   always_ff @(posedge clock) begin
      if (wr_peer) begin
         peer_ff[wr_idx] <= cmd_ff.peer_address;
      end
      if (wr_pb) begin
         prefix_ff[wr_idx] <= wr_prefix;
         base_ff[wr_idx]   <= wr_base;
      end
      if (wr_off) begin
         offset_ff[wr_idx] <= wr_offset;
      end
      if (wr_last) begin
         last_ff[wr_idx] <= wr_last_id;
      end
   end

endmodule

### tb/sv/peer_tunnel_id_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peer tunnel id allocator: self-checking testbench
// Drives set up, allocate, remove and no-op requests through the command port
// and keeps its own copy of the peer table and registers. Every request is
// predicted when it is accepted. Each result strobe is checked against the
// oldest expected beat. A short directed table comes first. Then come eight
// random phases, each with its own range bits and node role, whose addresses
// come mostly from a small pool so that the table fills and lookups hit.
// ----------------------------------------------------------------------------
module peer_tunnel_id_allocator_tb;
   import ptid_pkg::*;

   // codes with no name in the package
   localparam logic [1:0] ACT_NONE   = 2'd3;
   localparam logic [1:0] IF_NONE    = 2'd3;
   localparam logic [1:0] ROLE_OTHER = 2'd3;

   localparam int DIR_ROWS    = 24;
   localparam int FIRST_CFG   = 16;    // rows from here run with new settings
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 250;
   localparam int SETTLE      = PEER_ENTRIES + 8;

   // per-phase settings, phase 0 in the low bits
   localparam logic [31:0] PHASE_BITS =
      {4'd7, 4'd2, 4'd8, 4'd0, 4'd9, 4'd4, 4'd15, 4'd1};
   localparam logic [15:0] PHASE_ROLES =
      {ROLE_SGW, ROLE_OTHER, ROLE_COMBINED, ROLE_PGW,
       ROLE_SGW, ROLE_OTHER, ROLE_PGW, ROLE_COMBINED};

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row;

   logic    clock;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    busy;
   req_type req_item  = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the peer table and registers
   bit          tbl_valid  [PEER_ENTRIES];
   logic [31:0] tbl_peer   [PEER_ENTRIES];
   logic [7:0]  tbl_prefix [PEER_ENTRIES];
   logic [31:0] tbl_base   [PEER_ENTRIES];
   logic [31:0] tbl_offset [PEER_ENTRIES];
   logic [31:0] tbl_last   [PEER_ENTRIES];
   logic [3:0]  cfg_range_bits = '0;
   logic [1:0]  cfg_role       = ROLE_SGW;

   rsp_type     pending_ids [$];
   int          mismatch_count = 0;
   bit          idle_on        = 1'b1;
   logic [31:0] addr_pool [POOL_SIZE];
   stim_row     script [DIR_ROWS];

   peer_tunnel_id_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // outcome of one request, updating the shadow table as the block would
   function automatic rsp_type tunnel_id_outcome(input req_type r);
      rsp_type     res;
      int          slot;
      logic [3:0]  bits;
      logic [31:0] mask;
      logic [31:0] widened;
      logic [7:0]  pfx;
      logic        advance;
      res.status = ST_OK;
      res.teid   = '0;
      slot       = -1;
      bits       = (cfg_range_bits > 4'd8) ? 4'd8 : cfg_range_bits;
      mask       = FULL_MASK >> bits;
      // lowest matching valid slot wins
      for (int i = PEER_ENTRIES - 1; i >= 0; i--)
         if (tbl_valid[i] && tbl_peer[i] == r.peer_address) slot = i;
      case (r.action)
         ACT_SETUP: begin
            if (slot < 0) begin
               for (int i = PEER_ENTRIES - 1; i >= 0; i--)
                  if (!tbl_valid[i]) slot = i;
               if (slot < 0) begin
                  res.status = ST_TABLE_FULL;
               end else begin
                  tbl_valid[slot]  = 1'b1;
                  tbl_peer[slot]   = r.peer_address;
                  tbl_prefix[slot] = '0;
                  tbl_base[slot]   = FIRST_ID;
                  tbl_offset[slot] = '0;
                  tbl_last[slot]   = FIRST_ID;
               end
            end
            if (slot >= 0 && bits != 4'd0) begin
               widened          = {24'd0, r.range_value} << (PREFIX_BITS - bits);
               pfx              = widened[7:0];
               tbl_prefix[slot] = pfx;
               tbl_base[slot]   = (pfx == 8'd0) ? FIRST_ID : {pfx, 24'd0};
            end
         end
         ACT_ALLOC: begin
            if (slot < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               case (r.interface_select)
                  IF_S1U_SGW, IF_S5S8_SGW:
                     advance = (cfg_role == ROLE_SGW || cfg_role == ROLE_COMBINED);
                  IF_S5S8_PGW:
                     advance = (cfg_role == ROLE_PGW);
                  default:
                     advance = 1'b0;
               endcase
               if (advance) begin
                  tbl_last[slot]   = tbl_base[slot] + tbl_offset[slot];
                  tbl_offset[slot] = (tbl_offset[slot] >= mask) ? 32'd0
                                                                : tbl_offset[slot] + 32'd1;
               end
               res.teid = (tbl_last[slot] & mask) | {tbl_prefix[slot], 24'd0};
            end
         end
         ACT_REMOVE: begin
            if (slot < 0) res.status = ST_NOT_FOUND;
            else tbl_valid[slot] = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic stim_row row(input logic [1:0] act, input logic [31:0] addr,
                                   input logic [7:0] rval, input logic [1:0] ifc,
                                   input bit typed, input logic [1:0] st,
                                   input logic [31:0] id);
      stim_row s;
      s.item        = '{act, addr, rval, ifc};
      s.typed       = typed;
      s.want.status = st;
      s.want.teid   = id;
      return s;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      r.action = ACT_SETUP;
      else if (pick < 80) r.action = ACT_ALLOC;
      else if (pick < 92) r.action = ACT_REMOVE;
      else                r.action = ACT_NONE;
      if ($urandom_range(0, 99) < 85)
         r.peer_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         r.peer_address = $urandom;
      r.range_value      = 8'($urandom_range(0, 255));
      r.interface_select = 2'($urandom_range(0, 3));
      return r;
   endfunction

   // one request beat; start stays high afterwards unless the next call idles
   task automatic send_beat(input stim_row s);
      rsp_type predicted;
      if (idle_on && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= s.item;
      do @(posedge clock); while (busy);
      predicted = tunnel_id_outcome(s.item);
      pending_ids.push_back(s.typed ? s.want : predicted);
   endtask

   // stop sending and let every outstanding result come back
   task automatic drain();
      start <= 1'b0;
      while (pending_ids.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] bits, input logic [1:0] role);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_RANGE_BITS;
      csr_wdata <= bits;
      do @(posedge clock); while (!csr_ready);
      cfg_range_bits = bits;
      csr_index <= CSR_NODE_ROLE;
      csr_wdata <= {2'b00, role};
      do @(posedge clock); while (!csr_ready);
      cfg_role = role;
      csr_valid <= 1'b0;
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
   endtask

   // result beats: checked against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_ids.size() == 0) begin
            flag_mismatch("unexpected result, teid", 32'd0, rsp_item.teid);
         end else begin
            want = pending_ids.pop_front();
            if (rsp_item.status !== want.status)
               flag_mismatch("status", {30'd0, want.status}, {30'd0, rsp_item.status});
            if (rsp_item.teid !== want.teid)
               flag_mismatch("teid", want.teid, rsp_item.teid);
         end
      end
   end

   initial begin
      for (int i = 0; i < PEER_ENTRIES; i++) tbl_valid[i] = 1'b0;
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

      // directed rows; the first sixteen run with reset settings
      script[0]  = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_S1U_SGW,  1, ST_NOT_FOUND, 0);
      script[1]  = row(ACT_REMOVE, 32'hFFFF_FFFF, 8'h00, IF_S1U_SGW,  1, ST_NOT_FOUND, 0);
      script[2]  = row(ACT_NONE,   32'h1234_5678, 8'hFF, IF_NONE,     1, ST_OK, 0);
      script[3]  = row(ACT_SETUP,  32'h0000_0000, 8'hFF, IF_S1U_SGW,  1, ST_OK, 0);
      script[4]  = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_S1U_SGW,  1, ST_OK, 1);
      script[5]  = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_S5S8_SGW, 1, ST_OK, 2);
      script[6]  = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_S5S8_PGW, 1, ST_OK, 2);
      script[7]  = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_NONE,     1, ST_OK, 2);
      script[8]  = row(ACT_SETUP,  32'hFFFF_FFFF, 8'h00, IF_S1U_SGW,  1, ST_OK, 0);
      script[9]  = row(ACT_ALLOC,  32'hFFFF_FFFF, 8'h00, IF_S1U_SGW,  1, ST_OK, 1);
      script[10] = row(ACT_SETUP,  32'h0000_0000, 8'hAA, IF_S1U_SGW,  1, ST_OK, 0);
      script[11] = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_S5S8_SGW, 1, ST_OK, 3);
      script[12] = row(ACT_REMOVE, 32'h0000_0000, 8'h00, IF_S1U_SGW,  1, ST_OK, 0);
      script[13] = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_S1U_SGW,  1, ST_NOT_FOUND, 0);
      script[14] = row(ACT_SETUP,  32'h0000_0000, 8'h55, IF_S1U_SGW,  1, ST_OK, 0);
      script[15] = row(ACT_ALLOC,  32'h0000_0000, 8'h00, IF_S1U_SGW,  1, ST_OK, 1);
      // full prefix width, packet gateway role
      script[16] = row(ACT_SETUP,  32'hA5A5_A5A5, 8'hFF, IF_S1U_SGW,  0, ST_OK, 0);
      script[17] = row(ACT_ALLOC,  32'hA5A5_A5A5, 8'h00, IF_S5S8_PGW, 0, ST_OK, 0);
      script[18] = row(ACT_ALLOC,  32'hA5A5_A5A5, 8'h00, IF_S5S8_PGW, 0, ST_OK, 0);
      script[19] = row(ACT_ALLOC,  32'hA5A5_A5A5, 8'h00, IF_S1U_SGW,  0, ST_OK, 0);
      script[20] = row(ACT_SETUP,  32'hA5A5_A5A5, 8'h00, IF_S1U_SGW,  0, ST_OK, 0);
      script[21] = row(ACT_ALLOC,  32'hA5A5_A5A5, 8'h00, IF_S5S8_PGW, 0, ST_OK, 0);
      script[22] = row(ACT_ALLOC,  32'hFFFF_FFFF, 8'h00, IF_S5S8_PGW, 0, ST_OK, 0);
      script[23] = row(ACT_NONE,   32'h5A5A_5A5A, 8'h55, IF_NONE,     0, ST_OK, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == FIRST_CFG) set_config(4'd8, ROLE_PGW);
         send_beat(script[i]);
      end

      // random phases, each under its own settings
      for (int p = 0; p < PHASES; p++) begin
         stim_row s;
         set_config(PHASE_BITS[4*p +: 4], PHASE_ROLES[2*p +: 2]);
         idle_on = (p != 3);               // one phase back to back
         s.typed = 1'b0;
         s.want  = '0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == 5 && n == PHASE_BEATS / 2) drain();
            s.item = random_request();
            send_beat(s);
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
